@@ rtl/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared types, character codes, line phase codes and sentence kind lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

  localparam int unsigned FIELD_W = 5;
  localparam logic [FIELD_W-1:0] FIELD_LIMIT = 5'd20;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_BODY  = 3'd1;
  localparam logic [2:0] PH_CHECK = 3'd2;
  localparam logic [2:0] PH_BAD   = 3'd3;
  localparam logic [2:0] PH_ENDED = 3'd4;

  localparam logic [0:0] CMD_CHAR = 1'b0;
  localparam logic [0:0] CMD_EOL  = 1'b1;

  localparam logic [3:0] KIND_NONE = 4'd0;
  localparam logic [3:0] KIND_GGA  = 4'd1;
  localparam logic [3:0] KIND_RMC  = 4'd2;
  localparam logic [3:0] KIND_VTG  = 4'd3;
  localparam logic [3:0] KIND_HDT  = 4'd4;
  localparam logic [3:0] KIND_HDG  = 4'd5;
  localparam logic [3:0] KIND_MTW  = 4'd6;
  localparam logic [3:0] KIND_DBT  = 4'd7;
  localparam logic [3:0] KIND_DPT  = 4'd8;
  localparam logic [3:0] KIND_MWV  = 4'd9;
  localparam logic [3:0] KIND_MWD  = 4'd10;
  localparam logic [3:0] KIND_RMB  = 4'd11;

  typedef struct packed {
    logic [2:0]         line_phase;
    logic [7:0]         body_xor;
    logic [7:0]         received_sum;
    logic [1:0]         hex_digits_seen;
    logic               hex_bad;
    logic               star_seen;
    logic               in_address;
    logic [2:0]         address_length;
    logic [15:0]        talker_pair;
    logic [23:0]        last_three;
    logic [FIELD_W-1:0] fields_counted;
  } line_state_t;

  typedef struct packed {
    logic               start_ok;
    logic               checksum_present;
    logic               checksum_valid;
    logic               has_address;
    logic [7:0]         talker_first;
    logic [7:0]         talker_second;
    logic [7:0]         id_first;
    logic [7:0]         id_second;
    logic [7:0]         id_third;
    logic [FIELD_W-1:0] field_count;
    logic [3:0]         sentence_kind;
  } result_t;

  localparam line_state_t LINE_RESET = '{
    line_phase:      PH_IDLE,
    body_xor:        8'h00,
    received_sum:    8'h00,
    hex_digits_seen: 2'd0,
    hex_bad:         1'b0,
    star_seen:       1'b0,
    in_address:      1'b1,
    address_length:  3'd0,
    talker_pair:     16'h0000,
    last_three:      24'h000000,
    fields_counted:  '0
  };

  // Returns the digit value in the low four bits and an error flag on top.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    begin
      if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        r = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        r = {1'b0, 4'(c - 8'h57)};
      end else begin
        r = 5'b10000;
      end
      return r;
    end
  endfunction

  // Looks up the sentence identifier and checks the minimum field count.
  function automatic logic [3:0] kind_of(input logic [23:0] id,
                                         input logic [FIELD_W-1:0] fields);
    logic [3:0]         k;
    logic [FIELD_W-1:0] min_f;
    begin
      unique case (id)
        24'h474741: begin k = KIND_GGA; min_f = 5'd7;  end
        24'h524D43: begin k = KIND_RMC; min_f = 5'd9;  end
        24'h565447: begin k = KIND_VTG; min_f = 5'd6;  end
        24'h484454: begin k = KIND_HDT; min_f = 5'd2;  end
        24'h484447: begin k = KIND_HDG; min_f = 5'd2;  end
        24'h4D5457: begin k = KIND_MTW; min_f = 5'd2;  end
        24'h444254: begin k = KIND_DBT; min_f = 5'd4;  end
        24'h445054: begin k = KIND_DPT; min_f = 5'd2;  end
        24'h4D5756: begin k = KIND_MWV; min_f = 5'd6;  end
        24'h4D5744: begin k = KIND_MWD; min_f = 5'd6;  end
        24'h524D42: begin k = KIND_RMB; min_f = 5'd12; end
        default:    begin k = KIND_NONE; min_f = '0;   end
      endcase
      return (fields >= min_f) ? k : KIND_NONE;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/nsc_if.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker channels
// Valid/ready channels for incoming characters and outgoing line reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface nsc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       start_ok;
  logic                       checksum_present;
  logic                       checksum_valid;
  logic                       has_address;
  logic [7:0]                 talker_first;
  logic [7:0]                 talker_second;
  logic [7:0]                 id_first;
  logic [7:0]                 id_second;
  logic [7:0]                 id_third;
  logic [nsc_pkg::FIELD_W-1:0] field_count;
  logic [3:0]                 sentence_kind;

  modport source (output valid, start_ok, checksum_present, checksum_valid,
                  has_address, talker_first, talker_second, id_first,
                  id_second, id_third, field_count, sentence_kind,
                  input ready);
  modport sink   (input valid, start_ok, checksum_present, checksum_valid,
                  has_address, talker_first, talker_second, id_first,
                  id_second, id_third, field_count, sentence_kind,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/nsc_report.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker report
// Forms the end-of-line report from the accumulated line state.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_report (
  input  wire nsc_pkg::line_state_t line,
  output nsc_pkg::result_t          report
);

  logic start_ok;
  logic present;
  logic valid;
  logic addr;

  always_comb begin
    start_ok = (line.line_phase == nsc_pkg::PH_BODY) ||
               (line.line_phase == nsc_pkg::PH_CHECK) ||
               (line.line_phase == nsc_pkg::PH_ENDED);
    present  = start_ok && line.star_seen;
    valid    = present && (line.hex_digits_seen == 2'd2) && !line.hex_bad &&
               (line.received_sum == line.body_xor);
    addr     = start_ok && (line.address_length >= 3'd5);

    report.start_ok         = start_ok;
    report.checksum_present = present;
    report.checksum_valid   = valid;
    report.has_address      = addr;
    report.talker_first     = addr ? line.talker_pair[15:8] : 8'h00;
    report.talker_second    = addr ? line.talker_pair[7:0] : 8'h00;
    report.id_first         = addr ? line.last_three[23:16] : 8'h00;
    report.id_second        = addr ? line.last_three[15:8] : 8'h00;
    report.id_third         = addr ? line.last_three[7:0] : 8'h00;
    report.field_count      = start_ok ? line.fields_counted : '0;
    report.sentence_kind    = (valid && addr) ?
        nsc_pkg::kind_of(line.last_three, line.fields_counted) : nsc_pkg::KIND_NONE;
  end

endmodule

`default_nettype wire

@@ rtl/nmea_sentence_checker_unit.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Checks start character, checksum, address and field count of a line.
// ----------------------------------------------------------------------------
//  channel      dir   items
//  char_in      in    cmd, data_byte: one character or an end of line
//  report_out   out   one line report for each end of line
//
// A new item is accepted in each cycle while the input is not stalled.
// A character updates the line state registers directly; an end of line
// loads the report register and clears the line state in the same cycle.
// The report register holds its item until it is taken; input is stalled
// only while a report waits and report_out.ready is low.
// Reset clears the line state and empties the report register.
`default_nettype none

module nmea_sentence_checker_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  nsc_in_if.sink          char_in,
  nsc_out_if.source       report_out
);

  nsc_pkg::line_state_t line;
  nsc_pkg::line_state_t line_next;
  nsc_pkg::result_t     report_comb;
  nsc_pkg::result_t     report;
  logic                 out_valid;
  logic                 accept;
  logic [4:0]           nib;
  logic [7:0]           c;

  nsc_report u_report (
    .line   (line),
    .report (report_comb)
  );

  assign char_in.ready = !out_valid || report_out.ready;
  assign accept        = char_in.valid && char_in.ready;
  assign c             = char_in.data_byte;
  assign nib           = nsc_pkg::hex_nibble(c);

  always_comb begin
    line_next = line;
    unique case (line.line_phase)
      nsc_pkg::PH_IDLE: begin
        if (c == nsc_pkg::CH_DOLLAR || c == nsc_pkg::CH_BANG) begin
          line_next.line_phase     = nsc_pkg::PH_BODY;
          line_next.fields_counted = 5'd1;
        end else begin
          line_next.line_phase = nsc_pkg::PH_BAD;
        end
      end
      nsc_pkg::PH_BODY: begin
        priority if (c == nsc_pkg::CH_NUL) begin
          line_next.line_phase = nsc_pkg::PH_ENDED;
        end else if (c == nsc_pkg::CH_STAR) begin
          line_next.star_seen  = 1'b1;
          line_next.in_address = 1'b0;
          line_next.line_phase = nsc_pkg::PH_CHECK;
        end else if (c == nsc_pkg::CH_COMMA) begin
          line_next.body_xor   = line.body_xor ^ c;
          line_next.in_address = 1'b0;
          if (line.fields_counted < nsc_pkg::FIELD_LIMIT) begin
            line_next.fields_counted = line.fields_counted + 5'd1;
          end
        end else begin
          line_next.body_xor = line.body_xor ^ c;
          if (line.in_address) begin
            if (line.address_length == 3'd0) begin
              line_next.talker_pair = {c, 8'h00};
            end else if (line.address_length == 3'd1) begin
              line_next.talker_pair = {line.talker_pair[15:8], c};
            end
            line_next.last_three = {line.last_three[15:0], c};
            if (line.address_length != 3'd7) begin
              line_next.address_length = line.address_length + 3'd1;
            end
          end
        end
      end
      nsc_pkg::PH_CHECK: begin
        if (c == nsc_pkg::CH_NUL) begin
          line_next.line_phase = nsc_pkg::PH_ENDED;
        end else if (line.hex_digits_seen != 2'd2) begin
          if (nib[4]) begin
            line_next.hex_bad = 1'b1;
          end else begin
            line_next.received_sum = {line.received_sum[3:0], nib[3:0]};
          end
          line_next.hex_digits_seen = line.hex_digits_seen + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line      <= nsc_pkg::LINE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (accept && char_in.cmd == nsc_pkg::CMD_EOL) begin
        out_valid <= 1'b1;
      end else if (report_out.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (char_in.cmd == nsc_pkg::CMD_EOL) begin
          line <= nsc_pkg::LINE_RESET;
        end else begin
          line <= line_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && char_in.cmd == nsc_pkg::CMD_EOL) begin
      report <= report_comb;
    end
  end

  assign report_out.valid            = out_valid;
  assign report_out.start_ok         = report.start_ok;
  assign report_out.checksum_present = report.checksum_present;
  assign report_out.checksum_valid   = report.checksum_valid;
  assign report_out.has_address      = report.has_address;
  assign report_out.talker_first     = report.talker_first;
  assign report_out.talker_second    = report.talker_second;
  assign report_out.id_first         = report.id_first;
  assign report_out.id_second        = report.id_second;
  assign report_out.id_third         = report.id_third;
  assign report_out.field_count      = report.field_count;
  assign report_out.sentence_kind    = report.sentence_kind;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the NMEA sentence checker
// Feeds directed and random lines, character by character, into the checker
// and compares every line report with a predicted one. The sender and the
// receiver idle at random in the first two of three phases; the receiver
// also holds off once for a long stretch, stalling the checker's input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import nsc_pkg::*;

  localparam int ITEM_TARGET  = 940;
  localparam int LINE_TARGET  = 50;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [23:0] KIND_IDS [11] = '{
    "GGA", "RMC", "VTG", "HDT", "HDG", "MTW", "DBT", "DPT", "MWV", "MWD", "RMB"
  };
  localparam logic [3:0] KIND_CODES [11] = '{
    KIND_GGA, KIND_RMC, KIND_VTG, KIND_HDT, KIND_HDG, KIND_MTW,
    KIND_DBT, KIND_DPT, KIND_MWV, KIND_MWD, KIND_RMB
  };
  localparam int KIND_MIN_FIELDS [11] = '{7, 9, 6, 2, 2, 2, 4, 2, 6, 6, 12};

  class sentence_tracker;
    logic [2:0]  phase;
    logic [7:0]  body_sum;
    logic [7:0]  sum_rx;
    logic [1:0]  digits;
    logic        digit_bad;
    logic        star;
    logic        addr_open;
    logic [2:0]  addr_len;
    logic [15:0] talker;
    logic [23:0] tail_id;
    logic [4:0]  fields;
    result_t     reports_due[$];
    int          fails;

    function new();
      fails = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase     = PH_IDLE;
      body_sum  = 8'h00;
      sum_rx    = 8'h00;
      digits    = 2'd0;
      digit_bad = 1'b0;
      star      = 1'b0;
      addr_open = 1'b1;
      addr_len  = 3'd0;
      talker    = 16'h0000;
      tail_id   = 24'h000000;
      fields    = 5'd0;
    endfunction

    function void absorb_char(logic [7:0] c);
      logic [3:0] nib;
      logic       nib_ok;
      nib    = 4'd0;
      nib_ok = 1'b1;
      if (phase == PH_IDLE) begin
        if (c == CH_DOLLAR || c == CH_BANG) begin
          phase  = PH_BODY;
          fields = 5'd1;
        end else begin
          phase = PH_BAD;
        end
      end else if (phase == PH_BAD || phase == PH_ENDED) begin
      end else if (c == CH_NUL) begin
        phase = PH_ENDED;
      end else if (phase == PH_BODY) begin
        if (c == CH_STAR) begin
          star      = 1'b1;
          addr_open = 1'b0;
          phase     = PH_CHECK;
        end else begin
          body_sum = body_sum ^ c;
          if (c == CH_COMMA) begin
            addr_open = 1'b0;
            if (fields < FIELD_LIMIT) fields = fields + 5'd1;
          end else if (addr_open) begin
            if (addr_len == 3'd0) talker = {c, 8'h00};
            else if (addr_len == 3'd1) talker[7:0] = c;
            tail_id = {tail_id[15:0], c};
            if (addr_len < 3'd7) addr_len = addr_len + 3'd1;
          end
        end
      end else if (digits < 2'd2) begin
        if (c >= "0" && c <= "9") nib = 4'(c - 8'h30);
        else if (c >= "A" && c <= "F") nib = 4'(c - 8'h37);
        else if (c >= "a" && c <= "f") nib = 4'(c - 8'h57);
        else nib_ok = 1'b0;
        if (nib_ok) sum_rx = {sum_rx[3:0], nib};
        else digit_bad = 1'b1;
        digits = digits + 2'd1;
      end
    endfunction

    function void close_line();
      result_t r;
      r = '0;
      r.start_ok = (phase == PH_BODY || phase == PH_CHECK || phase == PH_ENDED);
      r.checksum_present = r.start_ok & star;
      r.checksum_valid = r.checksum_present && digits == 2'd2 && !digit_bad &&
                         sum_rx == body_sum;
      r.has_address = r.start_ok && addr_len >= 3'd5;
      if (r.has_address) begin
        r.talker_first  = talker[15:8];
        r.talker_second = talker[7:0];
        r.id_first      = tail_id[23:16];
        r.id_second     = tail_id[15:8];
        r.id_third      = tail_id[7:0];
      end
      if (r.start_ok) r.field_count = fields;
      r.sentence_kind = KIND_NONE;
      if (r.checksum_valid && r.has_address) begin
        for (int i = 0; i < 11; i++) begin
          if (tail_id == KIND_IDS[i] && int'(fields) >= KIND_MIN_FIELDS[i])
            r.sentence_kind = KIND_CODES[i];
        end
      end
      reports_due.push_back(r);
      clear_line();
    endfunction

    function void note_item(logic cmd, logic [7:0] c);
      if (cmd == CMD_EOL) close_line();
      else absorb_char(c);
    endfunction

    function string show(result_t r);
      return $sformatf({"start %0d star %0d valid %0d addr %0d talker %02h%02h ",
                        "id %02h%02h%02h fields %0d kind %0d"},
                       r.start_ok, r.checksum_present, r.checksum_valid, r.has_address,
                       r.talker_first, r.talker_second, r.id_first, r.id_second,
                       r.id_third, r.field_count, r.sentence_kind);
    endfunction

    function void check_report(result_t got);
      result_t want;
      logic    differs;
      if (reports_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected report: %s", show(got));
        return;
      end
      want = reports_due.pop_front();
      differs = want.start_ok !== got.start_ok ||
                want.checksum_present !== got.checksum_present ||
                want.checksum_valid !== got.checksum_valid ||
                want.has_address !== got.has_address ||
                want.talker_first !== got.talker_first ||
                want.talker_second !== got.talker_second ||
                want.id_first !== got.id_first ||
                want.id_second !== got.id_second ||
                want.id_third !== got.id_third ||
                want.field_count !== got.field_count ||
                want.sentence_kind !== got.sentence_kind;
      if (differs) begin
        fails++;
        if (fails <= 10) begin
          $display("report mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int waiting();
      return reports_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_idle;
  bit   hold_req;
  int   items_sent;
  int   lines_sent;
  int   quiet_cycles = 0;
  logic [7:0] line_buf[$];
  sentence_tracker sb = new();

  nsc_in_if  char_in();
  nsc_out_if report_out();

  nmea_sentence_checker_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .report_out (report_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (upper ? 8'h37 : 8'h57) + {4'h0, n};
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle) begin
      char_in.valid = 1'b0;
      @(negedge clk);
    end
    char_in.valid     = 1'b1;
    char_in.cmd       = cmd;
    char_in.data_byte = c;
    @(posedge clk);
    while (!char_in.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_item(CMD_CHAR, line_buf[i]);
    send_item(CMD_EOL, 8'($urandom_range(0, 255)));
    lines_sent++;
  endtask

  task automatic make_sentence();
    int         len;
    int         commas;
    int         mode;
    logic [7:0] sum;
    logic [7:0] c;
    logic [23:0] id;
    bit         upper;
    line_buf.delete();
    sum = 8'h00;
    line_buf.push_back($urandom_range(0, 3) == 0 ? CH_BANG : CH_DOLLAR);
    case ($urandom_range(0, 9))
      0: len = $urandom_range(0, 4);
      1: len = $urandom_range(6, 9);
      default: len = 5;
    endcase
    id = ($urandom_range(0, 3) != 0) ? KIND_IDS[$urandom_range(0, 10)] :
         {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
          8'($urandom_range(65, 90))};
    for (int i = 0; i < len; i++) begin
      if (len >= 5 && i >= len - 3) c = id[8 * (len - 1 - i) +: 8];
      else c = 8'($urandom_range(65, 90));
      line_buf.push_back(c);
      sum = sum ^ c;
    end
    commas = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 23) : $urandom_range(0, 9);
    for (int f = 0; f < commas; f++) begin
      line_buf.push_back(CH_COMMA);
      sum = sum ^ CH_COMMA;
      for (int k = $urandom_range(0, 2); k > 0; k--) begin
        c = 8'($urandom_range(46, 57));
        line_buf.push_back(c);
        sum = sum ^ c;
      end
    end
    mode  = $urandom_range(0, 9);
    upper = 1'($urandom_range(0, 1));
    if (mode == 7) return;
    line_buf.push_back(CH_STAR);
    if (mode == 8) begin
      if ($urandom_range(0, 1)) line_buf.push_back(hex_char(sum[7:4], upper));
      return;
    end
    if (mode == 9) begin
      if ($urandom_range(0, 1)) sum = sum ^ (8'h01 << $urandom_range(0, 7));
      else sum[3:0] = 4'h0;
    end
    line_buf.push_back(hex_char(sum[7:4], upper));
    if (mode == 9 && sum[3:0] == 4'h0 && $urandom_range(0, 1))
      line_buf.push_back($urandom_range(0, 1) ? "G" : "z");
    else
      line_buf.push_back(hex_char(sum[3:0], upper));
    if ($urandom_range(0, 3) == 0) begin
      line_buf.push_back(CH_COMMA);
      line_buf.push_back(8'($urandom_range(33, 126)));
    end
  endtask

  task automatic make_noise();
    line_buf.delete();
    if ($urandom_range(0, 1)) line_buf.push_back(CH_DOLLAR);
    for (int k = $urandom_range(0, 6); k > 0; k--)
      line_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin : monitor
    result_t got;
    logic    in_acc;
    logic    out_acc;
    if (!rst) begin
      in_acc  = char_in.valid && char_in.ready;
      out_acc = report_out.valid && report_out.ready;
      if (in_acc) sb.note_item(char_in.cmd, char_in.data_byte);
      if (out_acc) begin
        got.start_ok         = report_out.start_ok;
        got.checksum_present = report_out.checksum_present;
        got.checksum_valid   = report_out.checksum_valid;
        got.has_address      = report_out.has_address;
        got.talker_first     = report_out.talker_first;
        got.talker_second    = report_out.talker_second;
        got.id_first         = report_out.id_first;
        got.id_second        = report_out.id_second;
        got.id_third         = report_out.id_third;
        got.field_count      = report_out.field_count;
        got.sentence_kind    = report_out.sentence_kind;
        sb.check_report(got);
      end
      if (in_acc || out_acc) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    bit hold_done;
    report_out.ready = 1'b0;
    hold_done        = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done        = 1'b1;
        report_out.ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      report_out.ready = !rst && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    bit paused;
    bit held;
    rst               = 1'b1;
    char_in.valid     = 1'b0;
    char_in.cmd       = CMD_CHAR;
    char_in.data_byte = 8'h00;
    send_idle         = 31;
    recv_idle         = 62;
    hold_req          = 1'b0;
    items_sent        = 0;
    lines_sent        = 0;
    paused            = 1'b0;
    held              = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    line_buf.delete();
    send_line();
    line_buf = {CH_NUL};
    send_line();
    line_buf = {CH_DOLLAR, 8'hFF, CH_STAR, "f"};
    send_line();
    line_buf = {CH_BANG, CH_COMMA, CH_STAR, "2", "C", CH_COMMA, "x"};
    send_line();
    line_buf = {CH_DOLLAR, "A", CH_NUL, CH_COMMA};
    send_line();

    while (items_sent < ITEM_TARGET || lines_sent < LINE_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        send_idle = 31;
        recv_idle = 62;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        if (!paused) begin
          char_in.valid = 1'b0;
          while (sb.waiting() != 0) @(negedge clk);
          paused = 1'b1;
        end
        send_idle = 62;
        recv_idle = 31;
      end else begin
        send_idle = 0;
        recv_idle = 0;
        if (!held) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
      end
      if ($urandom_range(0, 5) == 0) make_noise();
      else make_sentence();
      send_line();
    end

    char_in.valid = 1'b0;
    while (sb.waiting() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.fails == 0 && sb.waiting() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
